### hdl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// shared types and constants for the sorted counter table
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int COUNTERS   = 256;
    localparam int COUNT_BITS = 16;
    localparam int ID_BITS    = $clog2(COUNTERS);
    localparam int N_BITS     = ID_BITS + 1;

    typedef logic [ID_BITS-1:0]           id_t;
    typedef logic [N_BITS-1:0]            cnt_t;
    typedef logic signed [COUNT_BITS-1:0] val_t;

    localparam logic [2:0] KIND_INC   = 3'd0;
    localparam logic [2:0] KIND_DEC   = 3'd1;
    localparam logic [2:0] KIND_RANGE = 3'd2;
    localparam logic [2:0] KIND_RDID  = 3'd3;
    localparam logic [2:0] KIND_RDRK  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_REFUSE = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_RANK_RD,
        S_RANK_WT,
        S_VAL_RD,
        S_VAL_WT,
        S_SRCH_RD,
        S_SRCH_WT,
        S_SRCH_UPD,
        S_X_RD,
        S_X_WT,
        S_SWAP_RD,
        S_SWAP_WT,
        S_WR_P,
        S_WR_X,
        S_WR_MAP_A,
        S_WR_MAP_B,
        S_RANGE2,
        S_DONE
    } state_t;

    // datapath commands
    typedef enum logic [4:0] {
        C_NONE,
        C_LOAD,
        C_CLEAR,
        C_RD_RANK,
        C_RD_VAL_P,
        C_CAP_VAL,
        C_SRCH_INIT_LO,
        C_SRCH_INIT_HI,
        C_SRCH_RD,
        C_SRCH_STEP,
        C_FIX_X,
        C_RD_X,
        C_CAP_X,
        C_RD_SWAP,
        C_CAP_SWAP,
        C_WR_P,
        C_WR_X,
        C_WR_MAP_A,
        C_WR_MAP_B,
        C_SAVE_LO,
        C_FIN_RANGE,
        C_FIN_STATUS,
        C_FIN_READ_ID,
        C_FIN_READ_RANK,
        C_CAP_RANK
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic srch_done;
        logic id_bad;
        logic rank_bad;
        logic at_limit;
    } stat_t;

endpackage

### hdl/sct_datapath.sv
// ----------------------------------------------------------------------------
// sct_datapath
// memories, search registers and result registers
// ----------------------------------------------------------------------------
module sct_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sct_pkg::cmd_t       cmd,
    input  logic [2:0]          kind,
    input  logic [7:0]          counter_id,
    input  logic signed [15:0]  low_value,
    input  logic signed [15:0]  high_value,
    input  logic [8:0]          active_counters,
    output sct_pkg::stat_t      stat,
    output logic signed [15:0]  value,
    output logic [7:0]          id_out,
    output logic [8:0]          in_range,
    output logic [1:0]          status
);
    import sct_pkg::*;

    // memories
    id_t  rank_mem [COUNTERS];
    id_t  ctr_mem  [COUNTERS];
    val_t val_mem  [COUNTERS];
    id_t  rank_rd_reg, ctr_rd_reg;
    val_t val_rd_reg;

    logic [2:0] kind_reg;
    id_t        id_reg;
    val_t       lowv_reg, highv_reg;
    cnt_t       n_reg;
    id_t        p_reg, x_reg, a_reg, b_reg;
    val_t       v_reg;
    cnt_t       lo_reg, hi_reg, first_reg;
    id_t        clr_reg;
    logic       strict_reg;
    val_t       key_reg;

    cnt_t n_next;
    cnt_t mid;
    logic left;
    id_t  addr_r;
    id_t  addr_v;

    always_comb
    begin
        if (active_counters == '0)
            n_next = cnt_t'(1);
        else if (active_counters > cnt_t'(COUNTERS))
            n_next = cnt_t'(COUNTERS);
        else
            n_next = cnt_t'(active_counters);
    end

    assign mid  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign left = strict_reg ? (val_rd_reg > key_reg) : (val_rd_reg >= key_reg);

    always_comb
    begin
        case (cmd)
            C_RD_VAL_P:  addr_v = rank_rd_reg;
            C_CAP_RANK:  addr_v = rank_rd_reg;
            C_SRCH_RD:   addr_v = mid[ID_BITS-1:0];
            C_RD_X:      addr_v = x_reg;
            C_FIN_READ_RANK: addr_v = id_reg;
            default:     addr_v = id_reg;
        endcase
        case (cmd)
            C_RD_SWAP:   addr_r = x_reg;
            default:     addr_r = p_reg;
        endcase
    end

    assign stat.clear_last = (clr_reg == id_t'(COUNTERS-1));
    assign stat.srch_done  = !(lo_reg < hi_reg);
    assign stat.id_bad     = !(cnt_t'(id_reg) < n_reg);
    assign stat.rank_bad   = !(cnt_t'(rank_rd_reg) < n_reg);
    assign stat.at_limit   = (kind_reg == KIND_INC)
                             ? (val_rd_reg == {1'b0, {(COUNT_BITS-1){1'b1}}})
                             : (val_rd_reg == {1'b1, {(COUNT_BITS-1){1'b0}}});

    // memory ports
    always_ff @(posedge clk)
    begin
        if (cmd == C_CLEAR)
        begin
            rank_mem[clr_reg] <= clr_reg;
            ctr_mem[clr_reg]  <= clr_reg;
            val_mem[clr_reg]  <= '0;
        end
        if (cmd == C_WR_P)
        begin
            ctr_mem[p_reg] <= b_reg;
            val_mem[p_reg] <= v_reg;
        end
        if (cmd == C_WR_X)
        begin
            ctr_mem[x_reg] <= a_reg;
            val_mem[x_reg] <= (kind_reg == KIND_INC) ? v_reg + val_t'(1) : v_reg - val_t'(1);
        end
        if (cmd == C_WR_MAP_A)
            rank_mem[a_reg] <= x_reg;
        if (cmd == C_WR_MAP_B)
            rank_mem[b_reg] <= p_reg;
        rank_rd_reg <= rank_mem[id_reg];
        ctr_rd_reg  <= ctr_mem[(cmd == C_RD_SWAP || cmd == C_RD_X) ? addr_r : addr_v];
        val_rd_reg  <= val_mem[addr_v];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            lo_reg  <= '0;
            hi_reg  <= '0;
        end
        else
        begin
            case (cmd)
                C_CLEAR: clr_reg <= clr_reg + id_t'(1);
                C_LOAD:
                begin
                    kind_reg  <= kind;
                    id_reg    <= counter_id[ID_BITS-1:0];
                    lowv_reg  <= low_value;
                    highv_reg <= high_value;
                    n_reg     <= n_next;
                end
                C_CAP_RANK: p_reg <= rank_rd_reg;
                C_CAP_VAL:  v_reg <= val_rd_reg;
                C_SRCH_INIT_LO:
                begin
                    lo_reg <= '0; hi_reg <= n_reg;
                    strict_reg <= (kind_reg == KIND_INC);
                    key_reg <= (kind_reg == KIND_RANGE) ? lowv_reg : v_reg;
                end
                C_SRCH_INIT_HI:
                begin
                    lo_reg <= '0; hi_reg <= n_reg;
                    strict_reg <= 1'b1; key_reg <= highv_reg;
                end
                C_SRCH_STEP:
                begin
                    if (left) hi_reg <= mid;
                    else      lo_reg <= mid + cnt_t'(1);
                end
                C_FIX_X:
                begin
                    if (kind_reg == KIND_INC)
                        x_reg <= (lo_reg == '0) ? p_reg : lo_reg[ID_BITS-1:0] - id_t'(1);
                    else
                        x_reg <= (lo_reg >= n_reg) ? p_reg : lo_reg[ID_BITS-1:0];
                end
                C_CAP_X:
                begin
                    if (val_rd_reg != v_reg) x_reg <= p_reg;
                    a_reg <= ctr_rd_reg;
                end
                C_CAP_SWAP: b_reg <= ctr_rd_reg;
                C_SAVE_LO:  first_reg <= lo_reg;
                default: ;
            endcase
        end
    end

    // result words
    always_ff @(posedge clk)
    begin
        case (cmd)
            C_LOAD:
            begin
                value <= '0; id_out <= counter_id;
                in_range <= '0; status <= ST_OK;
            end
            C_FIN_STATUS:
            begin
                value <= '0; status <= ST_RANGE;
            end
            C_FIN_READ_ID: value <= val_rd_reg;
            C_CAP_VAL:
            begin
                if (stat.at_limit && kind_reg != KIND_RDID)
                begin
                    value <= val_rd_reg; status <= ST_REFUSE;
                end
            end
            C_WR_X:
                value <= (kind_reg == KIND_INC) ? v_reg + val_t'(1) : v_reg - val_t'(1);
            C_FIN_READ_RANK:
            begin
                value <= val_rd_reg; id_out <= 8'(ctr_rd_reg);
            end
            C_FIN_RANGE:
                in_range <= (lo_reg > first_reg) ? 9'(lo_reg - first_reg) : '0;
            default: ;
        endcase
    end

endmodule

### hdl/sct_ctrl.sv
// ----------------------------------------------------------------------------
// sct_ctrl
// sequencer for searches, swaps and reads
// ----------------------------------------------------------------------------
module sct_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  logic [2:0]     kind,
    input  logic signed [15:0] low_value,
    input  logic signed [15:0] high_value,
    input  sct_pkg::stat_t stat,
    output sct_pkg::cmd_t  cmd
);
    import sct_pkg::*;

    state_t state_reg, state_next;
    logic   second_reg, second_next;
    logic [2:0] kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            second_reg <= 1'b0;
            kind_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            if (in_valid && in_ready)
                kind_reg <= kind;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd         = C_NONE;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd = C_CLEAR;
                if (stat.clear_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = C_LOAD;
                    second_next = 1'b0;
                    if (kind == KIND_RANGE)
                        state_next = (high_value >= low_value) ? S_SRCH_UPD : S_DONE;
                    else if (kind == KIND_RDRK)
                        state_next = S_VAL_RD;
                    else if (kind <= KIND_RDID)
                        state_next = S_RANK_RD;
                    else
                        state_next = S_DONE;
                end
            end
            S_RANK_RD: state_next = S_RANK_WT;
            S_RANK_WT:
            begin
                if (stat.id_bad || stat.rank_bad)
                begin
                    cmd = C_FIN_STATUS; state_next = S_DONE;
                end
                else
                begin
                    cmd = C_RD_VAL_P; state_next = S_VAL_WT;
                end
            end
            S_VAL_RD:
            begin
                if (stat.id_bad)
                begin
                    cmd = C_FIN_STATUS; state_next = S_DONE;
                end
                else
                begin
                    cmd = C_FIN_READ_RANK; state_next = S_VAL_WT;
                end
            end
            S_VAL_WT:
            begin
                if (kind_reg == KIND_RDRK)
                begin
                    cmd = C_FIN_READ_RANK; state_next = S_DONE;
                end
                else
                begin
                    cmd = C_CAP_RANK; state_next = S_X_RD;
                end
            end
            S_X_RD:
            begin
                if (kind_reg == KIND_RDID)
                begin
                    cmd = C_FIN_READ_ID; state_next = S_DONE;
                end
                else
                begin
                    cmd = C_CAP_VAL;
                    state_next = stat.at_limit ? S_DONE : S_SRCH_UPD;
                end
            end
            S_SRCH_UPD:
            begin
                cmd = second_reg ? C_SRCH_INIT_HI : C_SRCH_INIT_LO;
                state_next = S_SRCH_RD;
            end
            S_SRCH_RD:
            begin
                if (stat.srch_done)
                begin
                    if (kind_reg == KIND_RANGE)
                    begin
                        if (second_reg)
                        begin
                            cmd = C_FIN_RANGE; state_next = S_DONE;
                        end
                        else
                        begin
                            cmd = C_SAVE_LO; second_next = 1'b1;
                            state_next = S_SRCH_UPD;
                        end
                    end
                    else
                    begin
                        cmd = C_FIX_X; state_next = S_SWAP_RD;
                    end
                end
                else
                begin
                    cmd = C_SRCH_RD; state_next = S_SRCH_WT;
                end
            end
            S_SRCH_WT:
            begin
                cmd = C_SRCH_STEP; state_next = S_SRCH_RD;
            end
            S_SWAP_RD:
            begin
                cmd = C_RD_X; state_next = S_X_WT;
            end
            S_X_WT:
            begin
                cmd = C_CAP_X; state_next = S_SWAP_WT;
            end
            S_SWAP_WT:
            begin
                cmd = C_RD_SWAP; state_next = S_RANGE2;
            end
            S_RANGE2:
            begin
                cmd = C_CAP_SWAP; state_next = S_WR_P;
            end
            S_WR_P:
            begin
                cmd = C_WR_P; state_next = S_WR_X;
            end
            S_WR_X:
            begin
                cmd = C_WR_X; state_next = S_WR_MAP_A;
            end
            S_WR_MAP_A:
            begin
                cmd = C_WR_MAP_A; state_next = S_WR_MAP_B;
            end
            S_WR_MAP_B:
            begin
                cmd = C_WR_MAP_B; state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### hdl/sorted_counter_table.sv
// ----------------------------------------------------------------------------
// sorted_counter_table
// table of counters kept sorted by value, with id/rank maps
// ----------------------------------------------------------------------------
// One word in, one word out, and the next word is taken only once the result
// word has left. After reset a clearing pass loads the identity maps and zero
// values before the first word is taken. Increment and decrement run one
// binary search of at most 9 probes over the registered-read value memory,
// then swap reads and writes; an update at the counter limit is refused, and
// a range count runs two searches. The result word is held while out_ready
// stays low. The active count is to be written through cfg_we only while
// idle; the block itself does not enforce this.
module sorted_counter_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic [7:0]         counter_id,
    input  logic signed [15:0] low_value,
    input  logic signed [15:0] high_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] value,
    output logic [7:0]         id_out,
    output logic [8:0]         in_range,
    output logic [1:0]         status
);
    import sct_pkg::*;

    logic [8:0] active_reg;
    cmd_t       cmd;
    stat_t      stat;

    // active counter register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 9'd256;
        else if (cfg_we)
            active_reg <= cfg_data;
    end

    sct_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .low_value(low_value), .high_value(high_value),
        .stat(stat), .cmd(cmd)
    );

    sct_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .kind(kind), .counter_id(counter_id),
        .low_value(low_value), .high_value(high_value),
        .active_counters(active_reg), .stat(stat),
        .value(value), .id_out(id_out), .in_range(in_range), .status(status)
    );

endmodule
